FILE: src/lidar_polar_to_cartesian_top_defines.svh
// ----------------------------------------------------------------------------
// Lidar polar-to-cartesian converter: assertion macros
// Shorthand for clocked implication checks, with reset masking built in.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LP2C_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define LP2C_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lp2c_pkg.sv
// ----------------------------------------------------------------------------
// lp2c_pkg
// Shared widths, register codes and CORDIC constants of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lp2c_pkg;

   localparam int INDEX_W = 12;
   localparam int RANGE_W = 24;
   localparam int COORD_W = 25;
   localparam int ANGLE_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // Samples at or beyond this index are dropped.
   localparam int MAX_SAMPLES = 4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ANGLE = 3'd0,
      CSR_ANGLE_STEP  = 3'd1,
      CSR_RANGE_LOWER = 3'd2,
      CSR_RANGE_UPPER = 3'd3
   } csr_index_type;

   // atan(2^-i) as a binary angle, 2^32 per turn
   localparam logic [ANGLE_W-1:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

endpackage : lp2c_pkg

`default_nettype wire

FILE: src/lp2c_if.sv
// ----------------------------------------------------------------------------
// lp2c channel interfaces
// Valid/ready channels for samples, points and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lp2c_req_if import lp2c_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] sample_index;
   logic [RANGE_W-1:0] range_value;
   logic               range_invalid;

   modport source (output valid, sample_index, range_value, range_invalid, input ready);
   modport sink   (input valid, sample_index, range_value, range_invalid, output ready);
endinterface : lp2c_req_if

interface lp2c_rsp_if import lp2c_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic [INDEX_W-1:0]        point_index;

   modport source (output valid, x_coord, y_coord, point_index, input ready);
   modport sink   (input valid, x_coord, y_coord, point_index, output ready);
endinterface : lp2c_rsp_if

interface lp2c_csr_if import lp2c_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : lp2c_csr_if

`default_nettype wire

FILE: src/lidar_polar_to_cartesian_top.sv
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_top
// Range gate plus pipelined CORDIC: one lidar sample in, at most one x/y point out.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   -------   ---------  -------------------------------------------------
//   req_bus   in         sample_index, range_value, range_invalid
//   rsp_bus   out        x_coord, y_coord, point_index (kept samples only)
//   csr_bus   in         index, data (start angle, step, range gate limits)
//
// One sample per clock while the skid register is empty. A kept sample passes
// in turn through the capture, angle multiply and angle fold stages, the CORDIC
// stage chain, the gain multiply stage and the rounding output register.
// Synchronous reset clears all valid bits and the registers to their defaults;
// req_bus.ready and csr_bus.ready stay low while reset is high.
// A stall on rsp_bus fills a one-beat skid register; req_bus.ready drops only
// while that skid register is full, so the whole pipeline freezes in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_polar_to_cartesian_top_defines.svh"

module lidar_polar_to_cartesian_top import lp2c_pkg::*; #(
   parameter int CORDIC_STEPS = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lp2c_req_if.sink   req_bus,
   lp2c_rsp_if.source rsp_bus,
   lp2c_csr_if.sink   csr_bus
);

   // CORDIC datapath widths: |x|,|y| stay below 1.65 * 2^30, |z| below 2^31.
   localparam int XY_W   = 32;
   localparam int PROD_W = 64;
   localparam int RND_SHIFT = 36;
   localparam logic signed [XY_W-1:0]   GAIN_Q30   = 32'sh26DD3B6A;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sh0000_0008_0000_0000;
   localparam logic signed [PROD_W-1:0] COORD_MAX  = 64'sd16777215;
   localparam logic signed [PROD_W-1:0] COORD_MIN  = -64'sd16777215;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [ANGLE_W-1:0] start_angle_ff;
   logic [ANGLE_W-1:0] angle_step_ff;
   logic [RANGE_W-1:0] range_lower_ff;
   logic [RANGE_W-1:0] range_upper_ff;

   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         range_lower_ff <= '0;
         range_upper_ff <= '1;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_START_ANGLE: start_angle_ff <= csr_bus.data;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_bus.data;
            CSR_RANGE_LOWER: range_lower_ff <= csr_bus.data[RANGE_W-1:0];
            CSR_RANGE_UPPER: range_upper_ff <= csr_bus.data[RANGE_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline advance: everything moves unless the skid register is occupied
   // ------------------------------------------------------------------------
   logic pipe_en;
   logic skid_valid_ff;
   logic req_fire;
   logic sample_keep;

   assign pipe_en       = !skid_valid_ff;
   assign req_bus.ready = pipe_en && !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Range gate: drop flagged returns, out-of-bounds indexes and ranges outside
   // the inclusive window. An inverted window drops everything.
   assign sample_keep = !req_bus.range_invalid
                      && ({20'd0, req_bus.sample_index} < 32'(MAX_SAMPLES))
                      && (req_bus.range_value >= range_lower_ff)
                      && (req_bus.range_value <= range_upper_ff);

   // ------------------------------------------------------------------------
   // Stage A: capture the beat
   // ------------------------------------------------------------------------
   logic               sa_valid_ff;
   logic [INDEX_W-1:0] sa_idx_ff;
   logic [RANGE_W-1:0] sa_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sa_valid_ff <= req_fire && sample_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sa_idx_ff   <= req_bus.sample_index;
         sa_range_ff <= req_bus.range_value;
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: index times step, modulo a full turn
   // ------------------------------------------------------------------------
   logic               sb_valid_ff;
   logic [INDEX_W-1:0] sb_idx_ff;
   logic [RANGE_W-1:0] sb_range_ff;
   logic [ANGLE_W-1:0] sb_offset_ff;
   logic [ANGLE_W-1:0] sb_offset_in;

   assign sb_offset_in = ANGLE_W'({20'd0, sa_idx_ff} * angle_step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sb_idx_ff    <= sa_idx_ff;
         sb_range_ff  <= sa_range_ff;
         sb_offset_ff <= sb_offset_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage C: full angle, fold into +/- a quarter turn, seed the rotator
   // ------------------------------------------------------------------------
   logic                   cv_ff   [0:CORDIC_STEPS];
   logic [INDEX_W-1:0]     cidx_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] cx_ff   [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] cy_ff   [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] cz_ff   [0:CORDIC_STEPS];

   logic [ANGLE_W-1:0]     angle_full;
   logic                   angle_flip;
   logic signed [XY_W-1:0] seed_mag;
   logic signed [XY_W-1:0] cx_seed_in;
   logic signed [XY_W-1:0] cz_seed_in;

   assign angle_full = start_angle_ff + sb_offset_ff;
   // Top bits 01 or 10 lie in the back half-plane: rotate by half a turn.
   assign angle_flip = angle_full[ANGLE_W-1] ^ angle_full[ANGLE_W-2];
   assign seed_mag   = $signed({2'b00, sb_range_ff, 6'b000000});
   assign cx_seed_in = angle_flip ? -seed_mag : seed_mag;
   assign cz_seed_in = $signed({angle_full[ANGLE_W-1] ^ angle_flip,
                                angle_full[ANGLE_W-2:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         cv_ff[0] <= sb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cidx_ff[0] <= sb_idx_ff;
         cx_ff[0]   <= cx_seed_in;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= cz_seed_in;
      end
   end

   // ------------------------------------------------------------------------
   // CORDIC rotation stages, one micro-rotation each
   // ------------------------------------------------------------------------
   for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [XY_W-1:0] atan_val;
      logic signed [XY_W-1:0] cx_in;
      logic signed [XY_W-1:0] cy_in;
      logic signed [XY_W-1:0] cz_in;

      assign dx       = cy_ff[gi] >>> gi;
      assign dy       = cx_ff[gi] >>> gi;
      assign atan_val = $signed(ATAN_TABLE[gi]);

      // Rotate toward a zero residual angle.
      always_comb begin
         if (!cz_ff[gi][XY_W-1]) begin
            cx_in = cx_ff[gi] - dx;
            cy_in = cy_ff[gi] + dy;
            cz_in = cz_ff[gi] - atan_val;
         end else begin
            cx_in = cx_ff[gi] + dx;
            cy_in = cy_ff[gi] - dy;
            cz_in = cz_ff[gi] + atan_val;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[gi+1] <= 1'b0;
         end else if (pipe_en) begin
            cv_ff[gi+1] <= cv_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            cidx_ff[gi+1] <= cidx_ff[gi];
            cx_ff[gi+1]   <= cx_in;
            cy_ff[gi+1]   <= cy_in;
            cz_ff[gi+1]   <= cz_in;
         end
      end
   end : g_step

   // ------------------------------------------------------------------------
   // Stage M: scale by the CORDIC gain (Q2.30)
   // ------------------------------------------------------------------------
   logic                     mv_ff;
   logic [INDEX_W-1:0]       midx_ff;
   logic signed [PROD_W-1:0] mx_ff;
   logic signed [PROD_W-1:0] my_ff;
   logic signed [PROD_W-1:0] mx_in;
   logic signed [PROD_W-1:0] my_in;

   assign mx_in = PROD_W'(cx_ff[CORDIC_STEPS]) * PROD_W'(GAIN_Q30);
   assign my_in = PROD_W'(cy_ff[CORDIC_STEPS]) * PROD_W'(GAIN_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (pipe_en) begin
         mv_ff <= cv_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         midx_ff <= cidx_ff[CORDIC_STEPS];
         mx_ff   <= mx_in;
         my_ff   <= my_in;
      end
   end

   // Round half up, drop the fraction bits, clamp to the coordinate limit.
   function automatic logic signed [COORD_W-1:0] finish_coord(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] shifted;
      shifted = (prod + ROUND_HALF) >>> RND_SHIFT;
      if (shifted > COORD_MAX) begin
         return COORD_MAX[COORD_W-1:0];
      end else if (shifted < COORD_MIN) begin
         return COORD_MIN[COORD_W-1:0];
      end
      return shifted[COORD_W-1:0];
   endfunction

   logic signed [COORD_W-1:0] fin_x;
   logic signed [COORD_W-1:0] fin_y;

   assign fin_x = finish_coord(mx_ff);
   assign fin_y = finish_coord(my_ff);

   // ------------------------------------------------------------------------
   // Output register plus skid register
   // ------------------------------------------------------------------------
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      skid_valid_in;
   logic                      out_load_pipe;
   logic                      out_load_skid;
   logic                      skid_load;
   logic [INDEX_W-1:0]        out_idx_ff;
   logic signed [COORD_W-1:0] out_x_ff;
   logic signed [COORD_W-1:0] out_y_ff;
   logic [INDEX_W-1:0]        skid_idx_ff;
   logic signed [COORD_W-1:0] skid_x_ff;
   logic signed [COORD_W-1:0] skid_y_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load_pipe = 1'b0;
      out_load_skid = 1'b0;
      skid_load     = 1'b0;
      priority if (skid_valid_ff) begin
         // pipeline frozen; drain the skid beat once the sink takes the output
         if (rsp_bus.ready) begin
            out_load_skid = 1'b1;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !rsp_bus.ready) begin
         // output blocked: park an arriving beat in the skid register
         if (mv_ff) begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_load_pipe = 1'b1;
         out_valid_in  = mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load_skid) begin
         out_idx_ff <= skid_idx_ff;
         out_x_ff   <= skid_x_ff;
         out_y_ff   <= skid_y_ff;
      end else if (out_load_pipe) begin
         out_idx_ff <= midx_ff;
         out_x_ff   <= fin_x;
         out_y_ff   <= fin_y;
      end
      if (skid_load) begin
         skid_idx_ff <= midx_ff;
         skid_x_ff   <= fin_x;
         skid_y_ff   <= fin_y;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.x_coord     = out_x_ff;
   assign rsp_bus.y_coord     = out_y_ff;
   assign rsp_bus.point_index = out_idx_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `LP2C_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid beat without output beat")
   `LP2C_ASSERT_NEXT(a_blocked_beat_parked, clock, reset, pipe_en && mv_ff && out_valid_ff && !rsp_bus.ready, skid_valid_ff, "arriving beat lost while output blocked")
   `LP2C_ASSERT_NEXT(a_invalid_dropped, clock, reset, req_fire && req_bus.range_invalid, !sa_valid_ff, "flagged return entered the pipeline")
   `LP2C_ASSERT_NOW(a_coord_clamped, clock, reset, out_valid_ff, (out_x_ff != COORD_MIN[COORD_W-1:0] - 25'sd1) && (out_y_ff != COORD_MIN[COORD_W-1:0] - 25'sd1), "coordinate outside clamp range")

endmodule : lidar_polar_to_cartesian_top

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: lidar polar-to-cartesian converter testbench
// Streams range samples through the range gate and the CORDIC under several
// register settings, predicts every kept point with an independent
// fixed-point rotation, and checks each point beat in order.
// ----------------------------------------------------------------------------

module tb;
   import lp2c_pkg::*;

   localparam int CORDIC_STEPS = 20;

   // Pipeline depth allowance: the CORDIC chain plus the fixed stages around it.
   localparam int PIPE_LATENCY = CORDIC_STEPS + 4;
   // Quiet time after the last expected point: covers dropped samples still
   // walking down the pipe before a register write.
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 8;
   localparam int CYCLE_LIMIT  = 400000;

   // Long receiver hold-off used to back the pipe up into the sample channel.
   localparam int SINK_HOLD_CYCLES = 400;

   // Register index outside the map: a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   // Fixed-point constants of the rotation and of the output scaling.
   localparam longint GAIN_Q30    = 64'sh26DD3B6A;
   localparam longint ROUND_BIAS  = 64'sh8_0000_0000;
   localparam longint COORD_LIMIT = 64'sd16777215;
   localparam logic [RANGE_W-1:0] FULL_RANGE = {RANGE_W{1'b1}};

   // atan(2^-i) as a binary angle, 2^32 per turn
   localparam longint ROT_ATAN [0:31] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
      'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
      'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C,
      'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
      'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
      'h00000028, 'h00000014, 'h0000000A, 'h00000005,
      'h00000002, 'h00000001, 'h00000000, 'h00000000
   };

   typedef struct {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic [INDEX_W-1:0]        point_index;
   } point_type;

   logic clock;
   logic reset = 1'b1;

   lp2c_req_if req_bus ();
   lp2c_rsp_if rsp_bus ();
   lp2c_csr_if csr_bus ();

   lidar_polar_to_cartesian_top #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Shadow copy of the register file, updated on each accepted write beat.
   logic [ANGLE_W-1:0] gate_start_angle = '0;
   logic [ANGLE_W-1:0] gate_angle_step  = '0;
   logic [RANGE_W-1:0] gate_range_lower = '0;
   logic [RANGE_W-1:0] gate_range_upper = FULL_RANGE;

   point_type   pending_points [$];
   int unsigned mismatch_count   = 0;
   int unsigned cycle_count      = 0;
   bit          idling_on        = 1'b1;
   int unsigned sink_hold_cycles = 0;

   // -------------------------------------------------------------------------
   // Clock and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Every block input starts at a known value before the first edge.
   initial begin
      req_bus.valid         = 1'b0;
      req_bus.sample_index  = '0;
      req_bus.range_value   = '0;
      req_bus.range_invalid = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      rsp_bus.ready         = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Point predictor
   // -------------------------------------------------------------------------

   // Apply the CORDIC gain, round half up, clip to the coordinate range.
   function automatic logic signed [COORD_W-1:0] scale_and_clip(input longint acc);
      longint scaled;
      scaled = (acc * GAIN_Q30 + ROUND_BIAS) >>> 36;
      if (scaled > COORD_LIMIT)
         scaled = COORD_LIMIT;
      else if (scaled < -COORD_LIMIT)
         scaled = -COORD_LIMIT;
      return scaled[COORD_W-1:0];
   endfunction

   // Return 1 and the expected point when the sample survives the gate.
   function automatic bit predict_point(input logic [INDEX_W-1:0] idx,
                                        input logic [RANGE_W-1:0] r,
                                        input logic bad,
                                        output point_type pt);
      logic [ANGLE_W-1:0] turn;
      longint vx, vy, vz, dx, dy;
      pt = '{default: '0};
      if (bad || idx >= MAX_SAMPLES)
         return 1'b0;
      if (r < gate_range_lower || r > gate_range_upper)
         return 1'b0;

      turn = gate_start_angle + idx * gate_angle_step;
      vx   = r;
      vx   = vx * 64;
      // Fold the back half-plane onto the front one by a half turn.
      if (turn[ANGLE_W-1 -: 2] == 2'b01 || turn[ANGLE_W-1 -: 2] == 2'b10) begin
         turn = turn - 32'h8000_0000;
         vx   = -vx;
      end
      vy = 0;
      vz = $signed(turn);

      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vz >= 0) begin
            vx = vx - dx;
            vy = vy + dy;
            vz = vz - ROT_ATAN[i];
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            vz = vz + ROT_ATAN[i];
         end
      end

      pt.x_coord     = scale_and_clip(vx);
      pt.y_coord     = scale_and_clip(vy);
      pt.point_index = idx;
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Sample sender, register writer and drain
   // -------------------------------------------------------------------------

   // Offer one sample beat; on acceptance queue its point if it is kept.
   // Valid stays high into the next call when that call draws no gap.
   task automatic send_sample(input logic [INDEX_W-1:0] idx,
                              input logic [RANGE_W-1:0] r,
                              input logic bad);
      int unsigned gap;
      point_type   pt;
      gap = idling_on ? $urandom_range(11, 0) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample_index  <= idx;
      req_bus.range_value   <= r;
      req_bus.range_invalid <= bad;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (predict_point(idx, r, bad, pt))
         pending_points.insert(pending_points.size(), pt);
   endtask

   // One write beat; valid is left high for a following write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_START_ANGLE: gate_start_angle = value;
         CSR_ANGLE_STEP:  gate_angle_step  = value;
         CSR_RANGE_LOWER: gate_range_lower = value[RANGE_W-1:0];
         CSR_RANGE_UPPER: gate_range_upper = value[RANGE_W-1:0];
         default: ;
      endcase
   endtask

   // Program all four registers; optionally poke the unmapped index first.
   task automatic program_regs(input logic [ANGLE_W-1:0] start_angle,
                               input logic [ANGLE_W-1:0] angle_step,
                               input logic [RANGE_W-1:0] range_lower,
                               input logic [RANGE_W-1:0] range_upper,
                               input bit poke_spare);
      if (poke_spare)
         write_reg(CSR_SPARE_INDEX, $urandom);
      write_reg(CSR_START_ANGLE, start_angle);
      write_reg(CSR_ANGLE_STEP, angle_step);
      write_reg(CSR_RANGE_LOWER, {8'd0, range_lower});
      write_reg(CSR_RANGE_UPPER, {8'd0, range_upper});
      csr_bus.valid <= 1'b0;
   endtask

   // Drop valid, wait for every queued point, then let the pipe run empty.
   task automatic drain_points();
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A run of scan samples: mostly consecutive indexes with ranges inside
   // the gate, mixed with invalid returns, raw ranges and index jumps.
   task automatic scan_samples(input int count);
      logic [INDEX_W-1:0] idx;
      logic [RANGE_W-1:0] r;
      logic               bad;
      int unsigned        roll;
      idx = INDEX_W'($urandom_range(MAX_SAMPLES - 1, 0));
      repeat (count) begin
         roll = $urandom_range(99, 0);
         bad  = (roll < 5);
         if (roll < 15)
            r = RANGE_W'($urandom);
         else
            r = RANGE_W'($urandom_range(gate_range_upper, gate_range_lower));
         send_sample(idx, r, bad);
         if ($urandom_range(99, 0) < 5)
            idx = INDEX_W'($urandom);
         else
            idx = idx + 1'b1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Point sink: random stalls, plus one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : point_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = idling_on ? $urandom_range(11, 0) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Check each point beat against the oldest expected point.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point beat: index %0d x %0d y %0d",
                   rsp_bus.point_index, rsp_bus.x_coord, rsp_bus.y_coord);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_bus.x_coord !== want.x_coord) begin
               $error("x_coord: expected %0d, actual %0d", want.x_coord, rsp_bus.x_coord);
               mismatch_count++;
            end
            if (rsp_bus.y_coord !== want.y_coord) begin
               $error("y_coord: expected %0d, actual %0d", want.y_coord, rsp_bus.y_coord);
               mismatch_count++;
            end
            if (rsp_bus.point_index !== want.point_index) begin
               $error("point_index: expected %0d, actual %0d",
                      want.point_index, rsp_bus.point_index);
               mismatch_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset values: angle zero everywhere, gate fully open.
   task automatic test_reset_defaults();
      send_sample(12'd0, 24'd0, 1'b0);
      send_sample(12'd4095, FULL_RANGE, 1'b0);
      send_sample(12'd1, 24'h123456, 1'b1);
      send_sample(12'd2, 24'hABCDEF, 1'b0);
      send_sample(12'd4095, 24'd0, 1'b0);
      drain_points();
   endtask

   // Quadrants, fold boundaries and extreme angle registers at full range.
   task automatic test_angle_corners();
      // Quarter-turn steps; full range along the axes exercises clipping.
      program_regs(32'h0000_0000, 32'h4000_0000, 24'd0, FULL_RANGE, 1'b1);
      for (int q = 0; q < 4; q++)
         send_sample(q[INDEX_W-1:0], FULL_RANGE, 1'b0);
      drain_points();
      // Straddle each fold edge by one binary-angle unit.
      program_regs(32'h3FFF_FFFF, 32'h0000_0001, 24'd0, FULL_RANGE, 1'b0);
      send_sample(12'd0, 24'h80_0000, 1'b0);
      send_sample(12'd1, 24'h80_0000, 1'b0);
      drain_points();
      program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0, FULL_RANGE, 1'b0);
      send_sample(12'd0, 24'h40_0001, 1'b0);
      send_sample(12'd1, 24'h40_0001, 1'b0);
      drain_points();
      program_regs(32'hBFFF_FFFF, 32'h0000_0001, 24'd0, FULL_RANGE, 1'b0);
      send_sample(12'd0, 24'hC0_0000, 1'b0);
      send_sample(12'd1, 24'hC0_0000, 1'b0);
      drain_points();
      program_regs(32'h8000_0000, 32'hFFFF_FFFF, 24'd0, FULL_RANGE, 1'b0);
      send_sample(12'd0, 24'h00_0001, 1'b0);
      send_sample(12'd1, FULL_RANGE, 1'b0);
      drain_points();
   endtask

   // Gate edges: both bounds inclusive, a closed gate and a point-wide gate.
   task automatic test_range_gate();
      program_regs(32'h1000_0000, 32'h0100_0000, 24'd100, 24'd200, 1'b0);
      send_sample(12'd10, 24'd99, 1'b0);
      send_sample(12'd11, 24'd100, 1'b0);
      send_sample(12'd12, 24'd200, 1'b0);
      send_sample(12'd13, 24'd201, 1'b0);
      drain_points();
      // Lower above upper: nothing passes.
      program_regs(32'h1000_0000, 32'h0100_0000, 24'd200, 24'd100, 1'b0);
      send_sample(12'd14, 24'd150, 1'b0);
      drain_points();
      program_regs(32'h0000_0000, 32'h0000_0000, 24'd0, 24'd0, 1'b0);
      send_sample(12'd15, 24'd0, 1'b0);
      send_sample(12'd16, 24'd1, 1'b0);
      drain_points();
   endtask

   // Random scans under a series of register settings.
   task automatic test_random_scans();
      logic [RANGE_W-1:0] lo, hi, tmp;
      for (int phase = 0; phase < 7; phase++) begin
         lo = RANGE_W'($urandom);
         hi = RANGE_W'($urandom);
         if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
         end
         idling_on = (phase != 1);
         case (phase)
            0: begin
               // One full turn across the whole index space.
               program_regs($urandom, 32'h0010_0000, 24'd0, FULL_RANGE, 1'b0);
               scan_samples(320);
            end
            1: begin
               program_regs($urandom, $urandom, lo, hi, 1'b1);
               scan_samples(320);
            end
            2: begin
               program_regs(32'h8000_0000, 32'd0 - $urandom_range(1 << 22, 1), 24'd0,
                            hi, 1'b0);
               scan_samples(320);
            end
            3: begin
               program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0, FULL_RANGE, 1'b0);
               scan_samples(320);
            end
            4: begin
               // Half-turn step and a gate that passes only full range.
               program_regs($urandom, 32'h8000_0000, FULL_RANGE, FULL_RANGE, 1'b0);
               scan_samples(320);
            end
            5: begin
               program_regs($urandom, $urandom, hi, lo - 1'b1, 1'b0);
               scan_samples(40);
            end
            default: begin
               program_regs(32'h0000_0000, $urandom, 24'd0, 24'd0, 1'b0);
               scan_samples(100);
            end
         endcase
         drain_points();
      end
      idling_on = 1'b1;
   endtask

   // Hold the point sink off while samples keep coming, so the pipe fills
   // and the sample channel stalls.
   task automatic test_backpressure();
      program_regs($urandom, $urandom, 24'd0, FULL_RANGE, 1'b0);
      idling_on        = 1'b0;
      sink_hold_cycles = SINK_HOLD_CYCLES;
      for (int k = 0; k < 100; k++)
         send_sample(k[INDEX_W-1:0], RANGE_W'($urandom), 1'b0);
      drain_points();
      idling_on = 1'b1;
   endtask

   // Send a burst, pause until every point is back, then send another.
   task automatic test_sender_pause();
      program_regs($urandom, 32'h0001_0000, 24'd0, FULL_RANGE, 1'b0);
      scan_samples(30);
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      scan_samples(30);
      drain_points();
   endtask

   // -------------------------------------------------------------------------
   // Sequence and verdict
   // -------------------------------------------------------------------------
   initial begin : run_tests
      while (reset) @(posedge clock);
      test_reset_defaults();
      test_angle_corners();
      test_range_gate();
      test_random_scans();
      test_backpressure();
      test_sender_pause();
      if (mismatch_count == 0)
         $display("** lidar_polar_to_cartesian_top: PASSED **");
      else
         $display("** lidar_polar_to_cartesian_top: FAILED **");
      $finish;
   end

   // Cycle counter: stop a hung run well past the slowest legal one.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** lidar_polar_to_cartesian_top: FAILED **");
      $finish;
   end

endmodule : tb

FILE: lidar_polar_to_cartesian_top.f
+incdir+src
src/lp2c_pkg.sv
src/lp2c_if.sv
src/lidar_polar_to_cartesian_top.sv
tb/sv/tb.sv
